// ----- rtl/ccd_pkg.sv -----
// shared types, character codes and lookup functions for the console command decoder
// no dependencies; every module of the block imports this package
package ccd_pkg;

  // accumulator and quotient width
  localparam int unsigned ACC_W = 32;
  // widest power of ten divisor (10^7) fits in 24 bits
  localparam int unsigned DIV_W = 24;
  // divider remainder width, one bit above the divisor
  localparam int unsigned REM_W = 25;
  // quotient bits resolved per divider cycle, and the cycle count
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DIV_ITERS = ACC_W / DIV_RADIX_BITS;
  // job queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [5:0] POS_MAX       = 6'd63;
  localparam logic [5:0] FIRST_NUM_POS = 6'd3;
  localparam logic [2:0] FRAC_KEEP     = 3'd7;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_GAINS = 8'h65;  // e
  localparam logic [7:0] CH_FLY   = 8'h66;  // f
  localparam logic [7:0] CH_LOOK  = 8'h6C;  // l
  localparam logic [7:0] CH_HELP  = 8'h68;  // h

  typedef enum logic [2:0] {
    KIND_GAINS = 3'd0,
    KIND_FLY   = 3'd1,
    KIND_LOOK  = 3'd2,
    KIND_HELP  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // one unit of work for the back end: a field conversion, a result, or both
  typedef struct packed {
    logic              conv;       // field value needs converting
    logic              store_en;   // converted value is a saved gain
    logic              store_idx;  // 0 proportional, 1 integral
    logic              emit;       // produce a result
    kind_t             kind;
    logic [1:0]        ctl;
    logic [3:0]        mode;
    logic              neg;
    logic [2:0]        frac;
    logic [ACC_W-1:0]  accum;
  } job_t;

  // bit 2 marks a known controller letter
  function automatic logic [2:0] ctl_lookup(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      8'h74:   r = 3'b100;  // t throttle
      8'h61:   r = 3'b101;  // a aileron
      8'h72:   r = 3'b110;  // r rudder
      8'h68:   r = 3'b111;  // h elevator
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  // bit 4 marks a known mode letter
  function automatic logic [4:0] mode_lookup(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h74:   r = 5'h10;  // t takeoff
      8'h63:   r = 5'h11;  // c circle
      8'h6C:   r = 5'h12;  // l loop
      8'h67:   r = 5'h13;  // g straight
      8'h72:   r = 5'h14;  // r roll
      8'h62:   r = 5'h15;  // b backglide
      8'h68:   r = 5'h16;  // h halfcircle
      8'h75:   r = 5'h17;  // u climb
      8'h73:   r = 5'h18;  // s snake
      default: r = 5'h00;
    endcase
    return r;
  endfunction

  function automatic logic [DIV_W-1:0] pow10(input logic [2:0] n);
    logic [DIV_W-1:0] r;
    case (n)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ccd_in_if.sv -----
// character channel of the console command decoder
// no dependencies
interface ccd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_command;

  modport source (output valid, output text_char, output end_of_command, input ready);
  modport sink (input valid, input text_char, input end_of_command, output ready);
endinterface

// ----- rtl/ccd_out_if.sv -----
// result channel of the console command decoder
// no dependencies
interface ccd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command_kind;
  logic [1:0]         controller_sel;
  logic [3:0]         flight_mode;
  logic signed [31:0] value_p;
  logic signed [31:0] value_i;
  logic signed [31:0] value_d;

  modport source (output valid, output command_kind, output controller_sel,
                  output flight_mode, output value_p, output value_i, output value_d,
                  input ready);
  modport sink (input valid, input command_kind, input controller_sel,
                input flight_mode, input value_p, input value_i, input value_d,
                output ready);
endinterface

// ----- rtl/ccd_front.sv -----
// front end: per character parsing, decimal accumulation and job generation
// depends on ccd_pkg and ccd_in_if
module ccd_front #(
  parameter int unsigned MAX_FIELD_CHARS = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  ccd_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output ccd_pkg::job_t push_job
);
  import ccd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FIELD_CHARS + 1);

  logic [5:0]       pos_r, pos_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       tgt_r, tgt_nxt;
  logic [1:0]       fi_r, fi_nxt;
  logic             neg_r, neg_nxt;
  logic             seen_r, seen_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [ACC_W-1:0] accum_r, accum_nxt;
  logic [2:0]       frac_r, frac_nxt;
  logic             err_r, err_nxt;

  logic             accept;
  logic [7:0]       c;
  logic             last;
  logic             sep;
  logic             do_fc;
  logic             last_fld;
  logic             digit;
  logic [ACC_W+3:0] prod;
  logic             prod_ovf;
  logic [1:0]       fi_after;
  kind_t            kind;
  logic [1:0]       ctl;
  logic [3:0]       mode;
  logic [2:0]       ctl_c, ctl_t;
  logic [4:0]       mode_c, mode_t;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.text_char;
  assign last        = in_ch.end_of_command;

  assign digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign prod     = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + (ACC_W + 4)'(c[3:0]);
  assign prod_ovf = |prod[ACC_W+3:ACC_W];
  assign ctl_c    = ctl_lookup(c);
  assign mode_c   = mode_lookup(c);

  // character consumption
  always_comb begin
    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 6'd1;
    cmd_nxt   = cmd_r;
    tgt_nxt   = tgt_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    accum_nxt = accum_r;
    frac_nxt  = frac_r;
    err_nxt   = err_r;
    sep       = 1'b0;
    do_fc     = 1'b0;
    last_fld  = 1'b0;
    if (!err_r) begin
      if (pos_r == 6'd0) begin
        cmd_nxt = c;
        if (!(c == CH_GAINS || c == CH_FLY || c == CH_LOOK || c == CH_HELP)) begin
          err_nxt = 1'b1;
        end
      end else begin
        unique case (cmd_r)
          CH_GAINS: begin
            if (pos_r == 6'd1) begin
              tgt_nxt = c;
              if (!ctl_c[2]) err_nxt = 1'b1;
            end else if (pos_r >= FIRST_NUM_POS) begin
              if (fi_r < 2'd2 && c == CH_MINUS) begin
                sep = 1'b1;
              end else begin
                do_fc    = 1'b1;
                last_fld = (fi_r >= 2'd2);
              end
            end
          end
          CH_FLY: begin
            if (pos_r == 6'd1) begin
              tgt_nxt = c;
              if (!mode_c[4]) err_nxt = 1'b1;
            end
          end
          CH_LOOK: begin
            if (pos_r == 6'd1) begin
              if (c != CH_MINUS) err_nxt = 1'b1;
            end else begin
              do_fc    = 1'b1;
              last_fld = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (do_fc) begin
      if (cnt_r >= CW'(MAX_FIELD_CHARS)) begin
        err_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
        if (last_fld && cnt_r == '0 && (c == CH_MINUS || c == CH_PLUS)) begin
          neg_nxt = (c == CH_MINUS);
        end else if (c == CH_POINT) begin
          if (seen_r) err_nxt = 1'b1;
          seen_nxt = 1'b1;
        end else if (!digit) begin
          err_nxt = 1'b1;
        end else if (!seen_r) begin
          accum_nxt = prod_ovf ? '1 : prod[ACC_W-1:0];
        end else if (frac_r < FRAC_KEEP && !prod_ovf) begin
          accum_nxt = prod[ACC_W-1:0];
          frac_nxt  = frac_r + 3'd1;
        end
      end
    end
  end

  // result classification for the last character
  assign fi_after = sep ? fi_r + 2'd1 : fi_r;
  assign ctl_t    = ctl_lookup(tgt_nxt);
  assign mode_t   = mode_lookup(tgt_nxt);

  always_comb begin
    kind = KIND_ERROR;
    ctl  = 2'd0;
    mode = 4'd0;
    if (!err_nxt) begin
      unique case (cmd_nxt)
        CH_GAINS: begin
          if (fi_after >= 2'd2) begin
            kind = KIND_GAINS;
            ctl  = ctl_t[1:0];
          end
        end
        CH_FLY: begin
          if (pos_r != 6'd0) begin
            kind = KIND_FLY;
            mode = mode_t[3:0];
          end
        end
        CH_LOOK: begin
          if (pos_r != 6'd0) kind = KIND_LOOK;
        end
        CH_HELP: kind = KIND_HELP;
        default: ;
      endcase
    end
  end

  always_comb begin
    push_job.conv      = sep || (last && (kind == KIND_GAINS || kind == KIND_LOOK));
    push_job.store_en  = sep;
    push_job.store_idx = fi_r[0];
    push_job.emit      = last;
    push_job.kind      = kind;
    push_job.ctl       = ctl;
    push_job.mode      = mode;
    push_job.neg       = neg_nxt;
    push_job.frac      = frac_nxt;
    push_job.accum     = accum_nxt;
  end

  assign push = accept && (sep || last);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      pos_r   <= '0;
      cmd_r   <= '0;
      tgt_r   <= '0;
      fi_r    <= '0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      cnt_r   <= '0;
      accum_r <= '0;
      frac_r  <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      cmd_r <= cmd_nxt;
      tgt_r <= tgt_nxt;
      err_r <= err_nxt;
      fi_r  <= fi_after;
      if (sep) begin
        neg_r   <= 1'b0;
        seen_r  <= 1'b0;
        cnt_r   <= '0;
        accum_r <= '0;
        frac_r  <= '0;
      end else begin
        neg_r   <= neg_nxt;
        seen_r  <= seen_nxt;
        cnt_r   <= cnt_nxt;
        accum_r <= accum_nxt;
        frac_r  <= frac_nxt;
      end
    end
  end

endmodule

// ----- rtl/ccd_queue.sv -----
// short job queue between the front and back ends
// depends on ccd_pkg
module ccd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ccd_pkg::job_t push_job,
  output logic          full,
  output logic          pop_valid,
  output ccd_pkg::job_t pop_job,
  input  logic          pop
);
  import ccd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;

  assign full      = (count_r == (PW + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      if (push && !pop) count_r <= count_r + (PW + 1)'(1);
      else if (pop && !push) count_r <= count_r - (PW + 1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> pop_valid)
    else $error("job popped from an empty queue");

endmodule

// ----- rtl/ccd_back.sv -----
// back end: radix-16 fixed point converter, saved gains and result register
// depends on ccd_pkg and ccd_out_if
module ccd_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ccd_pkg::job_t q_job,
  output logic          q_pop,
  ccd_out_if.source     out_ch
);
  import ccd_pkg::*;

  localparam int unsigned NW = ACC_W + FRAC_BITS + 1;
  localparam int unsigned SW = $clog2(DIV_ITERS);

  bk_state_t        state_r, state_nxt;
  job_t             job_r;
  logic [SW-1:0]    step_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ACC_W-1:0] low_r, low_nxt;
  logic [ACC_W-1:0] quo_r, quo_nxt;
  logic             ovf_r;
  logic [DIV_W-1:0] div_r;
  logic [ACC_W-1:0] gains_r [2];

  logic             load_job;
  logic             div_step;
  logic             finish;
  logic             out_load;
  logic             slot_free;
  logic [DIV_W-1:0] div_in;
  logic [NW-1:0]    num_in;
  logic [REM_W-1:0] top_in;
  logic [ACC_W-1:0] conv;
  logic [ACC_W-1:0] mag;

  logic             out_valid_r;
  logic [2:0]       kind_r;
  logic [1:0]       ctl_r;
  logic [3:0]       mode_r;
  logic [ACC_W-1:0] vp_r, vi_r, vd_r;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_job  = 1'b0;
    div_step  = 1'b0;
    finish    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          load_job  = 1'b1;
          state_nxt = q_job.conv ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        div_step = 1'b1;
        if (step_r == SW'(DIV_ITERS - 1)) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!job_r.emit) begin
          finish    = 1'b1;
          state_nxt = BK_IDLE;
        end else if (slot_free) begin
          finish    = 1'b1;
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // rounded numerator: accum * 2^FRAC_BITS + divisor / 2
  assign div_in = pow10(q_job.frac);
  assign num_in = {1'b0, q_job.accum, {FRAC_BITS{1'b0}}} + NW'(div_in >> 1);
  assign top_in = REM_W'(num_in[NW-1:ACC_W]);

  always_comb begin
    logic [REM_W:0] trial;
    rem_nxt = rem_r;
    low_nxt = low_r;
    quo_nxt = quo_r;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      trial = {rem_nxt, low_nxt[ACC_W-1]};
      low_nxt = low_nxt << 1;
      if (trial >= (REM_W + 1)'(div_r)) begin
        rem_nxt = REM_W'(trial - (REM_W + 1)'(div_r));
        quo_nxt = {quo_nxt[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[REM_W-1:0];
        quo_nxt = {quo_nxt[ACC_W-2:0], 1'b0};
      end
    end
  end

  // saturate and apply the sign
  always_comb begin
    if (job_r.neg) begin
      mag  = (ovf_r || quo_r > 32'h8000_0000) ? 32'h8000_0000 : quo_r;
      conv = 32'd0 - mag;
    end else begin
      mag  = (ovf_r || quo_r > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_r;
      conv = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_job) step_r <= '0;
      else if (div_step) step_r <= step_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      job_r <= q_job;
      div_r <= div_in;
      rem_r <= top_in;
      low_r <= num_in[ACC_W-1:0];
      quo_r <= '0;
      ovf_r <= (top_in >= REM_W'(div_in));
    end else if (div_step) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
    end
    if (finish && job_r.store_en) gains_r[job_r.store_idx] <= conv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r <= job_r.kind;
      ctl_r  <= job_r.ctl;
      mode_r <= job_r.mode;
      case (job_r.kind)
        KIND_GAINS: begin
          vp_r <= gains_r[0];
          vi_r <= job_r.store_en ? conv : gains_r[1];
          vd_r <= job_r.store_en ? '0 : conv;
        end
        KIND_LOOK: begin
          vp_r <= conv;
          vi_r <= '0;
          vd_r <= '0;
        end
        default: begin
          vp_r <= '0;
          vi_r <= '0;
          vd_r <= '0;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.command_kind   = kind_r;
  assign out_ch.controller_sel = ctl_r;
  assign out_ch.flight_mode    = mode_r;
  assign out_ch.value_p        = vp_r;
  assign out_ch.value_i        = vi_r;
  assign out_ch.value_d        = vd_r;

  a_div_only_conv: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> job_r.conv)
    else $error("converter running for a job without a field");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE && job_r.emit && !slot_free) |=> state_r == BK_DONE)
    else $error("result dropped while the output register was full");

endmodule

// ----- rtl/console_command_decoder.sv -----
// console command decoder: one character per transfer in, one decoded command per result out
// a result reaches the output register after its job leaves the queue, for commands without a
// number directly, for gains and lookahead once the radix-16 converter has run
// throughput: one character per cycle; every decimal field costs the back end a converter run and a
// 4-entry job queue absorbs them, in_ready falls only while that queue is full
// reset: synchronous active-low rst_n clears parsing state, queue and output valid
module console_command_decoder #(
  parameter int unsigned MAX_FIELD_CHARS = 9,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ccd_in_if.sink    in_ch,
  ccd_out_if.source out_ch
);
  import ccd_pkg::*;

  // front to queue
  logic q_full;
  logic push;
  job_t push_job;

  // queue to back
  logic q_valid;
  logic q_pop;
  job_t q_job;

  // front end: walks the command one character per transfer, tracks the
  // current decimal field as an integer plus a count of fraction digits, and
  // queues a job at each gain separator and at the last character
  ccd_front #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decouples character intake from the multi-cycle conversions
  ccd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  // back end: rounds accum * 2^FRAC_BITS / 10^frac into signed fixed point,
  // keeps the proportional and integral gains, and fills the output register
  ccd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for console_command_decoder: sends command text one character per
// transfer, predicts every decoded command in step with the input, checks each result
// depends on ccd_pkg, ccd_in_if, ccd_out_if and the console_command_decoder rtl
module tb_top;
  import ccd_pkg::*;

  localparam int MAX_FIELD   = 9;
  localparam int FRAC_W      = 16;
  localparam int RANDOM_CHARS = 500;
  // the limit is far above the slowest run, so this only catches a hang
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam string CTL_LETTERS  = "tarh";
  localparam string MODE_LETTERS = "tclgrbhus";

  typedef logic [7:0] text_t[$];

  typedef struct {
    kind_t       kind;
    logic [1:0]  ctl;
    logic [3:0]  mode;
    logic [31:0] vp;
    logic [31:0] vi;
    logic [31:0] vd;
  } cmd_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ccd_in_if  in_ch ();
  ccd_out_if out_ch ();

  console_command_decoder #(
    .MAX_FIELD_CHARS(MAX_FIELD),
    .FRAC_BITS(FRAC_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // commands decoded so far and not yet seen on the result channel
  cmd_result_t decoded_cmds[$];
  int fail_count = 0;
  int chars_sent = 0;
  int cycle_count = 0;
  // calm stretches: neither side idles
  bit calm = 1'b0;
  int sink_hold = 0;
  text_t cmd_buf;

  // ---------------------------------------------------------------------------
  // decoder state as the bench tracks it
  // ---------------------------------------------------------------------------
  logic [5:0]  parse_pos;
  logic [7:0]  cmd_letter;
  logic [7:0]  tgt_letter;
  logic [1:0]  field_no;
  logic        field_neg;
  logic        field_point;
  logic [3:0]  field_len;
  logic [31:0] field_acc;
  logic [2:0]  field_frac;
  logic [31:0] held_gain [2];
  logic        cmd_bad;

  function automatic void clear_field();
    field_neg   = 1'b0;
    field_point = 1'b0;
    field_len   = '0;
    field_acc   = '0;
    field_frac  = '0;
  endfunction

  // everything but the held gains goes back to zero after a result
  function automatic void clear_command();
    parse_pos  = '0;
    cmd_letter = '0;
    tgt_letter = '0;
    field_no   = '0;
    cmd_bad    = 1'b0;
    clear_field();
  endfunction

  function automatic int controller_of(input logic [7:0] c);
    case (c)
      "t":     return 0;
      "a":     return 1;
      "r":     return 2;
      "h":     return 3;
      default: return -1;
    endcase
  endfunction

  function automatic int mode_of(input logic [7:0] c);
    case (c)
      "t":     return 0;
      "c":     return 1;
      "l":     return 2;
      "g":     return 3;
      "r":     return 4;
      "b":     return 5;
      "h":     return 6;
      "u":     return 7;
      "s":     return 8;
      default: return -1;
    endcase
  endfunction

  // decimal digits so far scaled to fixed point, rounded half up, then signed and clamped
  function automatic logic [31:0] field_value();
    logic [63:0] scale;
    logic [63:0] mag;
    scale = 64'd1;
    for (int k = 0; k < int'(field_frac); k++) scale = scale * 64'd10;
    mag = ((64'(field_acc) << FRAC_W) + (scale >> 1)) / scale;
    if (field_neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic void take_field_char(input logic [7:0] c, input logic last_field);
    logic [31:0] d;
    if (int'(field_len) >= MAX_FIELD) begin
      cmd_bad = 1'b1;
      return;
    end
    field_len = field_len + 4'd1;
    // a sign only as the first character of the final number
    if (last_field && field_len == 4'd1 && (c == CH_MINUS || c == CH_PLUS)) begin
      field_neg = (c == CH_MINUS);
      return;
    end
    if (c == CH_POINT) begin
      if (field_point) cmd_bad = 1'b1;
      field_point = 1'b1;
      return;
    end
    if (c < CH_ZERO || c > CH_NINE) begin
      cmd_bad = 1'b1;
      return;
    end
    d = 32'(c - CH_ZERO);
    if (!field_point) begin
      // integer part saturates the accumulator
      if (field_acc > (32'hFFFF_FFFF - d) / 32'd10) field_acc = 32'hFFFF_FFFF;
      else field_acc = field_acc * 32'd10 + d;
    end else if (field_frac < FRAC_KEEP && field_acc <= (32'hFFFF_FFFF - d) / 32'd10) begin
      // extra fraction digits are checked but dropped
      field_acc  = field_acc * 32'd10 + d;
      field_frac = field_frac + 3'd1;
    end
  endfunction

  function automatic void take_char(input logic [7:0] c, input logic [5:0] at);
    if (at == 6'd0) begin
      cmd_letter = c;
      if (c != CH_GAINS && c != CH_FLY && c != CH_LOOK && c != CH_HELP) cmd_bad = 1'b1;
      return;
    end
    case (cmd_letter)
      CH_GAINS: begin
        if (at == 6'd1) begin
          tgt_letter = c;
          if (controller_of(c) < 0) cmd_bad = 1'b1;
        end else if (at >= FIRST_NUM_POS) begin
          // a dash closes the proportional and integral fields
          if (field_no < 2'd2 && c == CH_MINUS) begin
            held_gain[field_no[0]] = field_value();
            field_no = field_no + 2'd1;
            clear_field();
          end else begin
            take_field_char(c, field_no >= 2'd2);
          end
        end
      end
      CH_FLY: begin
        if (at == 6'd1) begin
          tgt_letter = c;
          if (mode_of(c) < 0) cmd_bad = 1'b1;
        end
      end
      CH_LOOK: begin
        if (at == 6'd1) begin
          if (c != CH_MINUS) cmd_bad = 1'b1;
        end else begin
          take_field_char(c, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // advance the tracked state by one character; returns 1 when a command completes
  function automatic bit decode_char(input logic [7:0] c, input logic last,
                                     output cmd_result_t r);
    logic [5:0] at;
    at = parse_pos;
    r.kind = KIND_ERROR;
    r.ctl  = '0;
    r.mode = '0;
    r.vp   = '0;
    r.vi   = '0;
    r.vd   = '0;
    if (!cmd_bad) take_char(c, at);
    if (parse_pos < POS_MAX) parse_pos = parse_pos + 6'd1;
    if (!last) return 1'b0;
    if (!cmd_bad) begin
      case (cmd_letter)
        CH_GAINS: begin
          // truncated before the third gain stays an error
          if (field_no >= 2'd2) begin
            r.kind = KIND_GAINS;
            r.ctl  = 2'(controller_of(tgt_letter));
            r.vp   = held_gain[0];
            r.vi   = held_gain[1];
            r.vd   = field_value();
          end
        end
        CH_FLY: begin
          if (at >= 6'd1) begin
            r.kind = KIND_FLY;
            r.mode = 4'(mode_of(tgt_letter));
          end
        end
        CH_LOOK: begin
          if (at >= 6'd1) begin
            r.kind = KIND_LOOK;
            r.vp   = field_value();
          end
        end
        CH_HELP: r.kind = KIND_HELP;
        default: ;
      endcase
    end
    clear_command();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // result side stalls
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      sink_hold <= idle_len() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cmd_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_cmds.size() == 0) begin
        $display("%0t unexpected result: kind %0d p %h i %h d %h", $time,
                 out_ch.command_kind, out_ch.value_p, out_ch.value_i, out_ch.value_d);
        fail_count++;
      end else begin
        want = decoded_cmds.pop_front();
        check_field("command_kind", 32'(want.kind), 32'(out_ch.command_kind));
        check_field("controller_sel", 32'(want.ctl), 32'(out_ch.controller_sel));
        check_field("flight_mode", 32'(want.mode), 32'(out_ch.flight_mode));
        check_field("value_p", want.vp, out_ch.value_p);
        check_field("value_i", want.vi, out_ch.value_i);
        check_field("value_d", want.vd, out_ch.value_d);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, decoded_cmds.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // one character transfer; the prediction is made at the accepting edge
  task automatic push_char(input logic [7:0] c, input logic last);
    int gap;
    cmd_result_t r;
    gap = (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.text_char      <= c;
    in_ch.end_of_command <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (decode_char(c, last, r)) decoded_cmds.push_back(r);
    chars_sent++;
  endtask

  // whole command, end marker on its final character
  task automatic send_cmd(input text_t t);
    for (int i = 0; i < t.size(); i++) push_char(t[i], i == t.size() - 1);
  endtask

  function automatic text_t as_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) cmd_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  // "[sign]digits[.digits]", now and then long enough to saturate or overflow the field
  function automatic void add_number(input bit signed_ok);
    if (signed_ok && $urandom_range(0, 3) == 0)
      cmd_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3));
    if ($urandom_range(0, 1)) begin
      cmd_buf.push_back(CH_POINT);
      add_digits($urandom_range(0, 6));
    end
  endfunction

  // builds one random command in cmd_buf: mostly well formed, some corrupted or noise
  function automatic void make_command();
    int pick;
    int at;
    cmd_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      cmd_buf.push_back(CH_GAINS);
      cmd_buf.push_back($urandom_range(0, 9) ? CTL_LETTERS[$urandom_range(0, 3)] : any_byte());
      cmd_buf.push_back($urandom_range(0, 2) ? CH_MINUS : any_byte());
      add_number(1'b0);
      cmd_buf.push_back(CH_MINUS);
      add_number(1'b0);
      cmd_buf.push_back(CH_MINUS);
      add_number(1'b1);
    end else if (pick < 60) begin
      cmd_buf.push_back(CH_FLY);
      cmd_buf.push_back($urandom_range(0, 9) ? MODE_LETTERS[$urandom_range(0, 8)] : any_byte());
      repeat ($urandom_range(0, 2)) cmd_buf.push_back(any_byte());
    end else if (pick < 85) begin
      cmd_buf.push_back(CH_LOOK);
      cmd_buf.push_back($urandom_range(0, 9) ? CH_MINUS : any_byte());
      add_number(1'b1);
    end else if (pick < 90) begin
      cmd_buf.push_back(CH_HELP);
      repeat ($urandom_range(0, 3)) cmd_buf.push_back(any_byte());
    end else begin
      repeat ($urandom_range(1, 8)) cmd_buf.push_back(any_byte());
    end
    // corrupt one character or cut the command short
    if (cmd_buf.size() > 1 && $urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 1)) begin
        at = $urandom_range(0, cmd_buf.size() - 1);
        cmd_buf[at] = any_byte();
      end else begin
        at = $urandom_range(1, cmd_buf.size() - 1);
        while (cmd_buf.size() > at) void'(cmd_buf.pop_back());
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // help, extra characters ignored, position counter saturating on a very long line
  task automatic test_help();
    send_cmd(as_text("h"));
    send_cmd(as_text("hq-9"));
    cmd_buf = as_text("h");
    repeat (66) cmd_buf.push_back(any_byte());
    send_cmd(cmd_buf);
  endtask

  // every mode letter, an unknown one, a missing one, trailing junk
  task automatic test_fly();
    for (int i = 0; i < MODE_LETTERS.len(); i++) begin
      cmd_buf = as_text("f");
      cmd_buf.push_back(MODE_LETTERS[i]);
      send_cmd(cmd_buf);
    end
    send_cmd(as_text("fz"));
    send_cmd(as_text("f"));
    send_cmd(as_text("fsx"));
  endtask

  // all controllers, signed final gain, saturation and the malformed forms
  task automatic test_gains();
    send_cmd(as_text("et-1.5-0.25--3"));
    send_cmd(as_text("ea:0-0-+2.0000005"));
    send_cmd(as_text("er-99999-.5-32768"));
    send_cmd(as_text("eh-999999999-0.0000152-7"));
    send_cmd(as_text("ex-1-2-3"));
    send_cmd(as_text("et-1234567890-1-1"));
    send_cmd(as_text("et-1a-2-3"));
    send_cmd(as_text("et-1..2-0-0"));
    send_cmd(as_text("et-+1-0-0"));
    send_cmd(as_text("et-1-2-3-4"));
    send_cmd(as_text("et-1-2"));
    send_cmd(as_text("et-1-2-"));
  endtask

  // distance with both signs, negative limit, long fraction, missing dash or value
  task automatic test_lookahead();
    send_cmd(as_text("l-12.5"));
    send_cmd(as_text("l--32768"));
    send_cmd(as_text("l--99999"));
    send_cmd(as_text("l-+7"));
    send_cmd(as_text("l-.12345678"));
    send_cmd(as_text("l-"));
    send_cmd(as_text("lx5"));
    send_cmd(as_text("l"));
  endtask

  // unknown command letters, including control and high bytes
  task automatic test_unknown();
    send_cmd(as_text("q"));
    cmd_buf.delete();
    cmd_buf.push_back(8'hFF);
    cmd_buf.push_back(8'h00);
    send_cmd(cmd_buf);
    cmd_buf.delete();
    cmd_buf.push_back(8'h00);
    send_cmd(cmd_buf);
  endtask

  // random commands with calm and busy stretches
  task automatic test_random();
    int n;
    n = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      make_command();
      send_cmd(cmd_buf);
      n++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.text_char      <= '0;
    in_ch.end_of_command <= 1'b0;
    clear_command();
    held_gain[0] = '0;
    held_gain[1] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_help();
    test_fly();
    test_gains();
    test_lookahead();
    test_unknown();
    test_random();

    in_ch.valid <= 1'b0;
    while (decoded_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
